// ----- sv/assert_macros.svh -----
// Assertion macros shared by the detector RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Clocked check, disabled while reset is held.
`define ASSERT_DIS(lbl, ck, rn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);
// Clocked check that also holds through reset.
`define ASSERT_ALW(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);
`else
`define ASSERT_DIS(lbl, ck, rn, prop, msg)
`define ASSERT_ALW(lbl, ck, prop, msg)
`endif

`endif

// ----- sv/scld_pkg.sv -----
// Types, constants and helpers for the surface cell detector.
package scld_pkg;

  localparam int POS_W          = 6;
  localparam int DENS_W         = 8;
  localparam int LEVEL_W        = 3;
  localparam int IDX_W          = 16;
  localparam int SIDE_W         = 6;
  localparam int FLOD_W         = 3;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 6;
  localparam int STEP_W         = 3;

  localparam int SIDE_MAX_DEF   = 33;
  localparam int LOD_LEVELS_DEF = 7;
  localparam int SIDE_MIN       = 2;

  localparam logic [SIDE_W-1:0] SIDE_RST   = 6'd33;
  localparam logic [FLOD_W-1:0] FLOD_RST   = 3'd0;
  localparam logic              LODEN_RST  = 1'b1;

  localparam logic [DENS_W-1:0] INSIDE_LIMIT = 8'd127;

  localparam logic [STEP_W-1:0] LAST_STEP = 3'd7;
  localparam logic [STEP_W-1:0] NEAR_STEP = 3'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIDE       = 2'd0,
    REG_FIRST_LOD  = 2'd1,
    REG_LOD_ENABLE = 2'd2
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NN,
    ST_MX,
    ST_MY,
    ST_ADD,
    ST_WR,
    ST_LVL,
    ST_CORNER,
    ST_FOLD,
    ST_PUSH,
    ST_FLUSH
  } state_t;

  typedef enum logic [2:0] {
    MV_NONE,
    MV_SUB_X,
    MV_SUB_Y,
    MV_SUB_Z,
    MV_ADD_Y,
    MV_ADD_Z
  } move_t;

  typedef struct packed {
    logic we;
    logic re;
  } vol_ctl_t;

  // Walk the cube corners 7,6,4,5,1,0,2,3: one axis flips per step.
  function automatic move_t corner_move(input logic [STEP_W-1:0] step);
    move_t mv;
    case (step)
      3'd0:    mv = MV_SUB_Z;
      3'd1:    mv = MV_SUB_Y;
      3'd2:    mv = MV_ADD_Z;
      3'd3:    mv = MV_SUB_X;
      3'd4:    mv = MV_SUB_Z;
      3'd5:    mv = MV_ADD_Y;
      3'd6:    mv = MV_ADD_Z;
      default: mv = MV_NONE;
    endcase
    return mv;
  endfunction

endpackage

// ----- sv/scld_vol.sv -----
// Single-port density volume store with registered read data.
module scld_vol #(
  parameter int DEPTH = scld_pkg::SIDE_MAX_DEF * scld_pkg::SIDE_MAX_DEF * scld_pkg::SIDE_MAX_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  scld_pkg::vol_ctl_t          ctl,
  input  logic [AW-1:0]               addr,
  input  logic [scld_pkg::DENS_W-1:0] wdata,
  output logic [scld_pkg::DENS_W-1:0] rdata
);

  logic [scld_pkg::DENS_W-1:0] mem [DEPTH];
  logic [scld_pkg::DENS_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[addr] <= wdata;
    end
    if (ctl.re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/surface_cell_lod_detector_unit.sv -----
// Top level of the surface cell detector with detail levels.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall   | density, pos_x, pos_y, pos_z
//   out     | output    | out_valid/out_stall | level, cell_index, last
//   cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// Sequence: each item is accepted, has its address formed and its byte stored; then each
// level is considered in turn, and a level whose cube is examined takes eight corner
// reads through the single-port volume memory, then a fold; each extra result is pushed,
// and the final result is flushed.
// Reset clears control state only; the volume memory holds no defined value until written.
// A stalled result holds the sequencer in its push or flush step.
`include "assert_macros.svh"

module surface_cell_lod_detector_unit #(
  parameter int SIDE_MAX   = scld_pkg::SIDE_MAX_DEF,
  parameter int LOD_LEVELS = scld_pkg::LOD_LEVELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [scld_pkg::DENS_W-1:0]     in_density,
  input  logic [scld_pkg::POS_W-1:0]      in_pos_x,
  input  logic [scld_pkg::POS_W-1:0]      in_pos_y,
  input  logic [scld_pkg::POS_W-1:0]      in_pos_z,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [scld_pkg::LEVEL_W-1:0]    out_level,
  output logic [scld_pkg::IDX_W-1:0]      out_cell_index,
  output logic                            out_last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [scld_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [scld_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int DEPTH = SIDE_MAX * SIDE_MAX * SIDE_MAX;
  localparam int AW    = $clog2(DEPTH);
  localparam int NW    = $clog2(SIDE_MAX + 1);
  localparam int NNW   = $clog2(SIDE_MAX * SIDE_MAX + 1);
  localparam int CW    = (NW > scld_pkg::POS_W) ? NW : scld_pkg::POS_W;
  localparam int PW    = CW + NNW;
  localparam int LVW   = $clog2(LOD_LEVELS + 1);
  localparam int SW    = LOD_LEVELS + 1;
  localparam int EW    = (SW > scld_pkg::POS_W) ? SW : scld_pkg::POS_W;

  scld_pkg::state_t state_r, state_nxt;

  logic [scld_pkg::SIDE_W-1:0]  side_r;
  logic [scld_pkg::FLOD_W-1:0]  flod_r;
  logic                         loden_r;

  logic [scld_pkg::POS_W-1:0]   x_r, y_r, z_r;
  logic [scld_pkg::DENS_W-1:0]  dens_r;
  logic [NNW-1:0]               nn_r;
  logic [PW-1:0]                p_r;
  logic [AW-1:0]                base_r, addr_r, near_r;
  logic [LVW-1:0]               lv_r;
  logic [scld_pkg::STEP_W-1:0]  step_r;
  logic                         any_in_r, any_out_r, rdv_r;

  logic                         pend_r;
  logic [scld_pkg::LEVEL_W-1:0] pend_lv_r;
  logic [scld_pkg::IDX_W-1:0]   pend_idx_r;

  logic                         out_valid_r;
  logic [scld_pkg::LEVEL_W-1:0] out_level_r;
  logic [scld_pkg::IDX_W-1:0]   out_idx_r;
  logic                         out_last_r;

  logic [NW-1:0]                n_eff;
  logic                         oob, flod_bad, done, elig, sfc, out_free;
  logic [EW-1:0]                s_e, m_e, xe, ye, ze;
  logic [AW-1:0]                ox, oy, oz, addr_next, vol_addr;
  scld_pkg::move_t              move;
  logic [CW-1:0]                mul_a;
  logic [NNW-1:0]               mul_b;
  logic [PW-1:0]                prod;
  scld_pkg::vol_ctl_t           vol_ctl;
  logic [scld_pkg::DENS_W-1:0]  rd_data;
  logic                         rd_in, fold_in, fold_out;

  // Effective side, saturated to the supported range.
  always_comb begin
    if (CW'(side_r) < CW'(scld_pkg::SIDE_MIN)) begin
      n_eff = NW'(scld_pkg::SIDE_MIN);
    end else if (CW'(side_r) > CW'(SIDE_MAX)) begin
      n_eff = NW'(SIDE_MAX);
    end else begin
      n_eff = NW'(side_r);
    end
  end

  assign oob = (CW'(x_r) >= CW'(n_eff)) || (CW'(y_r) >= CW'(n_eff)) ||
               (CW'(z_r) >= CW'(n_eff));
  assign flod_bad = loden_r && (4'(flod_r) >= 4'(LOD_LEVELS));
  assign done = loden_r ? (lv_r >= LVW'(LOD_LEVELS)) : (lv_r >= LVW'(1));

  assign s_e  = EW'(1) << lv_r;
  assign m_e  = s_e - EW'(1);
  assign xe   = EW'(x_r);
  assign ye   = EW'(y_r);
  assign ze   = EW'(z_r);
  assign elig = (xe >= s_e) && (ye >= s_e) && (ze >= s_e) &&
                ((xe & m_e) == '0) && ((ye & m_e) == '0) && ((ze & m_e) == '0);

  assign ox   = AW'(nn_r) << lv_r;
  assign oy   = AW'(n_eff) << lv_r;
  assign oz   = AW'(1) << lv_r;
  assign move = scld_pkg::corner_move(step_r);

  always_comb begin
    case (move)
      scld_pkg::MV_SUB_X: addr_next = addr_r - ox;
      scld_pkg::MV_SUB_Y: addr_next = addr_r - oy;
      scld_pkg::MV_SUB_Z: addr_next = addr_r - oz;
      scld_pkg::MV_ADD_Y: addr_next = addr_r + oy;
      scld_pkg::MV_ADD_Z: addr_next = addr_r + oz;
      default:            addr_next = addr_r;
    endcase
  end

  assign prod = PW'(mul_a) * PW'(mul_b);

  assign rd_in    = (rd_data <= scld_pkg::INSIDE_LIMIT);
  assign fold_in  = any_in_r | (rdv_r & rd_in);
  assign fold_out = any_out_r | (rdv_r & ~rd_in);
  assign sfc      = fold_in & fold_out;
  assign out_free = ~out_valid_r | ~out_stall;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      scld_pkg::ST_IDLE:   if (in_valid) state_nxt = scld_pkg::ST_NN;
      scld_pkg::ST_NN:     state_nxt = oob ? scld_pkg::ST_IDLE : scld_pkg::ST_MX;
      scld_pkg::ST_MX:     state_nxt = scld_pkg::ST_MY;
      scld_pkg::ST_MY:     state_nxt = scld_pkg::ST_ADD;
      scld_pkg::ST_ADD:    state_nxt = scld_pkg::ST_WR;
      scld_pkg::ST_WR:     state_nxt = flod_bad ? scld_pkg::ST_IDLE : scld_pkg::ST_LVL;
      scld_pkg::ST_LVL: begin
        if (done) begin
          state_nxt = pend_r ? scld_pkg::ST_FLUSH : scld_pkg::ST_IDLE;
        end else if (elig) begin
          state_nxt = scld_pkg::ST_CORNER;
        end
      end
      scld_pkg::ST_CORNER: if (step_r == scld_pkg::LAST_STEP) state_nxt = scld_pkg::ST_FOLD;
      scld_pkg::ST_FOLD:   state_nxt = (sfc && pend_r) ? scld_pkg::ST_PUSH : scld_pkg::ST_LVL;
      scld_pkg::ST_PUSH:   if (out_free) state_nxt = scld_pkg::ST_LVL;
      scld_pkg::ST_FLUSH:  if (out_free) state_nxt = scld_pkg::ST_IDLE;
      default:             state_nxt = scld_pkg::ST_IDLE;
    endcase
  end

  // State outputs: handshake, memory control, multiplier operands.
  always_comb begin
    in_stall   = 1'b1;
    vol_ctl.we = 1'b0;
    vol_ctl.re = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    case (state_r)
      scld_pkg::ST_IDLE:   in_stall = 1'b0;
      scld_pkg::ST_NN: begin
        mul_a = CW'(n_eff);
        mul_b = NNW'(n_eff);
      end
      scld_pkg::ST_MX: begin
        mul_a = CW'(x_r);
        mul_b = NNW'(p_r);
      end
      scld_pkg::ST_MY: begin
        mul_a = CW'(y_r);
        mul_b = NNW'(n_eff);
      end
      scld_pkg::ST_WR:     vol_ctl.we = 1'b1;
      scld_pkg::ST_CORNER: vol_ctl.re = 1'b1;
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  assign vol_addr = (state_r == scld_pkg::ST_WR) ? base_r : addr_r;

  scld_vol #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_vol (
    .clk   (clk),
    .ctl   (vol_ctl),
    .addr  (vol_addr),
    .wdata (dens_r),
    .rdata (rd_data)
  );

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= scld_pkg::ST_IDLE;
      side_r      <= scld_pkg::SIDE_RST;
      flod_r      <= scld_pkg::FLOD_RST;
      loden_r     <= scld_pkg::LODEN_RST;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      rdv_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rdv_r   <= (state_r == scld_pkg::ST_CORNER);
      if (cfg_valid) begin
        case (scld_pkg::cfg_reg_t'(cfg_index))
          scld_pkg::REG_SIDE:       side_r  <= cfg_data[scld_pkg::SIDE_W-1:0];
          scld_pkg::REG_FIRST_LOD:  flod_r  <= cfg_data[scld_pkg::FLOD_W-1:0];
          scld_pkg::REG_LOD_ENABLE: loden_r <= cfg_data[0];
          default: begin
            side_r <= side_r;
          end
        endcase
      end
      if (state_r == scld_pkg::ST_FOLD && sfc) begin
        pend_r <= 1'b1;
      end else if (state_r == scld_pkg::ST_FLUSH && out_free) begin
        pend_r <= 1'b0;
      end
      if ((state_r == scld_pkg::ST_PUSH || state_r == scld_pkg::ST_FLUSH) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      scld_pkg::ST_IDLE: begin
        if (in_valid) begin
          x_r    <= in_pos_x;
          y_r    <= in_pos_y;
          z_r    <= in_pos_z;
          dens_r <= in_density;
        end
      end
      scld_pkg::ST_NN: p_r <= prod;
      scld_pkg::ST_MX: begin
        nn_r <= NNW'(p_r);
        p_r  <= prod;
      end
      scld_pkg::ST_MY: begin
        base_r <= AW'(p_r) + AW'(z_r);
        p_r    <= prod;
      end
      scld_pkg::ST_ADD: base_r <= base_r + AW'(p_r);
      scld_pkg::ST_WR:  lv_r <= loden_r ? LVW'(flod_r) : '0;
      scld_pkg::ST_LVL: begin
        addr_r    <= base_r;
        step_r    <= '0;
        any_in_r  <= 1'b0;
        any_out_r <= 1'b0;
        if (!done && !elig) begin
          lv_r <= lv_r + LVW'(1);
        end
      end
      scld_pkg::ST_CORNER: begin
        addr_r    <= addr_next;
        step_r    <= step_r + scld_pkg::STEP_W'(1);
        any_in_r  <= fold_in;
        any_out_r <= fold_out;
        if (step_r == scld_pkg::NEAR_STEP) begin
          near_r <= addr_r;
        end
      end
      scld_pkg::ST_FOLD: begin
        if (sfc && !pend_r) begin
          pend_lv_r  <= scld_pkg::LEVEL_W'(lv_r);
          pend_idx_r <= scld_pkg::IDX_W'(near_r);
        end
        if (!(sfc && pend_r)) begin
          lv_r <= lv_r + LVW'(1);
        end
      end
      scld_pkg::ST_PUSH: begin
        if (out_free) begin
          out_level_r <= pend_lv_r;
          out_idx_r   <= pend_idx_r;
          out_last_r  <= 1'b0;
          pend_lv_r   <= scld_pkg::LEVEL_W'(lv_r);
          pend_idx_r  <= scld_pkg::IDX_W'(near_r);
          lv_r        <= lv_r + LVW'(1);
        end
      end
      scld_pkg::ST_FLUSH: begin
        if (out_free) begin
          out_level_r <= pend_lv_r;
          out_idx_r   <= pend_idx_r;
          out_last_r  <= 1'b1;
        end
      end
      default: begin
        step_r <= step_r;
      end
    endcase
  end

  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_level      = out_level_r;
  assign out_cell_index = out_idx_r;
  assign out_last       = out_last_r;

  `ASSERT_DIS(a_nonlast_has_next, clk, rst_n, out_valid && !out_last |-> pend_r, "result not marked last with nothing pending")
  `ASSERT_DIS(a_last_drains, clk, rst_n, out_valid && out_last |-> !pend_r, "last result shown while a result is pending")
  `ASSERT_DIS(a_out_from_seq, clk, rst_n, $rose(out_valid) |-> $past(state_r) == scld_pkg::ST_PUSH || $past(state_r) == scld_pkg::ST_FLUSH, "result appeared outside push or flush")
  `ASSERT_DIS(a_lv_bound, clk, rst_n, state_r == scld_pkg::ST_LVL |-> lv_r <= LVW'(LOD_LEVELS), "level counter ran past the level count")
  `ASSERT_ALW(a_rst_out, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the surface cell detector with detail levels.
module tb;
  import scld_pkg::*;

  localparam int ITEM_TARGET    = 310;
  localparam int IDLE_WAIT      = 100;
  localparam int STALL_MAX      = 4;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int VOL_DEPTH      = SIDE_MAX_DEF * SIDE_MAX_DEF * SIDE_MAX_DEF;
  localparam logic [7:0] CODE_ALL_OUT = 8'h00;
  localparam logic [7:0] CODE_ALL_IN  = 8'hff;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [IDX_W-1:0]   cell_index;
    logic               last;
  } cell_t;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_NONE,
    ROW_HIT
  } row_kind_t;

  typedef struct packed {
    row_kind_t           kind;
    cfg_reg_t            reg_sel;
    logic [5:0]          wdata;
    logic [DENS_W-1:0]   dens;
    logic [POS_W-1:0]    px;
    logic [POS_W-1:0]    py;
    logic [POS_W-1:0]    pz;
    logic [LEVEL_W-1:0]  lvl;
    logic [IDX_W-1:0]    idx;
  } row_t;

  localparam row_t PLAN [0:35] = '{
    '{ROW_NONE, REG_SIDE,       6'd0, 8'd0,   6'd0,  6'd0,  6'd0,  3'd0, 16'd0},
    '{ROW_NONE, REG_SIDE,       6'd0, 8'd255, 6'd63, 6'd63, 6'd63, 3'd0, 16'd0},
    '{ROW_NONE, REG_SIDE,       6'd0, 8'd255, 6'd33, 6'd0,  6'd0,  3'd0, 16'd0},
    '{ROW_CFG,  REG_SIDE,       6'd0, 8'd0,   6'd0,  6'd0,  6'd0,  3'd0, 16'd0},
    '{ROW_NONE, REG_SIDE,       6'd0, 8'd127, 6'd0,  6'd0,  6'd1,  3'd0, 16'd0},
    '{ROW_NONE, REG_SIDE,       6'd0, 8'd128, 6'd0,  6'd1,  6'd0,  3'd0, 16'd0},
    '{ROW_NONE, REG_SIDE,       6'd0, 8'd255, 6'd0,  6'd1,  6'd1,  3'd0, 16'd0},
    '{ROW_NONE, REG_SIDE,       6'd0, 8'd200, 6'd1,  6'd0,  6'd0,  3'd0, 16'd0},
    '{ROW_NONE, REG_SIDE,       6'd0, 8'd50,  6'd1,  6'd0,  6'd1,  3'd0, 16'd0},
    '{ROW_NONE, REG_SIDE,       6'd0, 8'd90,  6'd1,  6'd1,  6'd0,  3'd0, 16'd0},
    '{ROW_HIT,  REG_SIDE,       6'd0, 8'd255, 6'd1,  6'd1,  6'd1,  3'd0, 16'd0},
    '{ROW_NONE, REG_SIDE,       6'd0, 8'd0,   6'd2,  6'd0,  6'd0,  3'd0, 16'd0},
    '{ROW_CFG,  REG_LOD_ENABLE, 6'd0, 8'd0,   6'd0,  6'd0,  6'd0,  3'd0, 16'd0},
    '{ROW_HIT,  REG_SIDE,       6'd0, 8'd0,   6'd1,  6'd1,  6'd1,  3'd0, 16'd0},
    '{ROW_NONE, REG_SIDE,       6'd0, 8'd128, 6'd0,  6'd0,  6'd0,  3'd0, 16'd0},
    '{ROW_NONE, REG_SIDE,       6'd0, 8'd129, 6'd0,  6'd0,  6'd1,  3'd0, 16'd0},
    '{ROW_NONE, REG_SIDE,       6'd0, 8'd254, 6'd1,  6'd0,  6'd1,  3'd0, 16'd0},
    '{ROW_NONE, REG_SIDE,       6'd0, 8'd255, 6'd1,  6'd1,  6'd0,  3'd0, 16'd0},
    '{ROW_NONE, REG_SIDE,       6'd0, 8'd200, 6'd1,  6'd1,  6'd1,  3'd0, 16'd0},
    '{ROW_HIT,  REG_SIDE,       6'd0, 8'd127, 6'd1,  6'd1,  6'd1,  3'd0, 16'd0},
    '{ROW_CFG,  REG_LOD_ENABLE, 6'd1, 8'd0,   6'd0,  6'd0,  6'd0,  3'd0, 16'd0},
    '{ROW_CFG,  REG_SIDE,       6'd63, 8'd0,  6'd0,  6'd0,  6'd0,  3'd0, 16'd0},
    '{ROW_CFG,  REG_FIRST_LOD,  6'd5, 8'd0,   6'd0,  6'd0,  6'd0,  3'd0, 16'd0},
    '{ROW_NONE, REG_SIDE,       6'd0, 8'd0,   6'd0,  6'd0,  6'd0,  3'd0, 16'd0},
    '{ROW_NONE, REG_SIDE,       6'd0, 8'd1,   6'd0,  6'd0,  6'd32, 3'd0, 16'd0},
    '{ROW_NONE, REG_SIDE,       6'd0, 8'd64,  6'd0,  6'd32, 6'd0,  3'd0, 16'd0},
    '{ROW_NONE, REG_SIDE,       6'd0, 8'd127, 6'd0,  6'd32, 6'd32, 3'd0, 16'd0},
    '{ROW_NONE, REG_SIDE,       6'd0, 8'd100, 6'd32, 6'd0,  6'd0,  3'd0, 16'd0},
    '{ROW_NONE, REG_SIDE,       6'd0, 8'd30,  6'd32, 6'd0,  6'd32, 3'd0, 16'd0},
    '{ROW_NONE, REG_SIDE,       6'd0, 8'd126, 6'd32, 6'd32, 6'd0,  3'd0, 16'd0},
    '{ROW_NONE, REG_SIDE,       6'd0, 8'd127, 6'd32, 6'd32, 6'd32, 3'd0, 16'd0},
    '{ROW_HIT,  REG_SIDE,       6'd0, 8'd128, 6'd32, 6'd32, 6'd32, 3'd5, 16'd0},
    '{ROW_CFG,  REG_FIRST_LOD,  6'd7, 8'd0,   6'd0,  6'd0,  6'd0,  3'd0, 16'd0},
    '{ROW_NONE, REG_SIDE,       6'd0, 8'd255, 6'd32, 6'd32, 6'd32, 3'd0, 16'd0},
    '{ROW_CFG,  REG_FIRST_LOD,  6'd6, 8'd0,   6'd0,  6'd0,  6'd0,  3'd0, 16'd0},
    '{ROW_NONE, REG_SIDE,       6'd0, 8'd0,   6'd32, 6'd32, 6'd32, 3'd0, 16'd0}
  };

  logic                  clk;
  logic                  rst_n          = 1'b0;
  logic                  in_valid       = 1'b0;
  logic                  in_stall;
  logic [DENS_W-1:0]     in_density     = '0;
  logic [POS_W-1:0]      in_pos_x       = '0;
  logic [POS_W-1:0]      in_pos_y       = '0;
  logic [POS_W-1:0]      in_pos_z       = '0;
  logic                  out_valid;
  logic                  out_stall      = 1'b0;
  logic [LEVEL_W-1:0]    out_level;
  logic [IDX_W-1:0]      out_cell_index;
  logic                  out_last;
  logic                  cfg_valid      = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index      = '0;
  logic [CFG_DATA_W-1:0] cfg_data       = '0;

  logic [SIDE_W-1:0]     side_reg  = SIDE_RST;
  logic [FLOD_W-1:0]     flod_reg  = FLOD_RST;
  logic                  loden_reg = LODEN_RST;
  logic [DENS_W-1:0]     vox_byte    [VOL_DEPTH];
  bit                    vox_written [VOL_DEPTH];

  cell_t due_cells[$];
  cell_t fresh_cells[$];
  int    item_count  = 0;
  int    err_count   = 0;
  int    stall_left  = 0;
  int    idle_cycles = 0;
  bit    no_idle     = 1'b0;

  surface_cell_lod_detector_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_density     (in_density),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_pos_z       (in_pos_z),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_level      (out_level),
    .out_cell_index (out_cell_index),
    .out_last       (out_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int side_now();
    int n = side_reg;
    if (n < SIDE_MIN) n = SIDE_MIN;
    if (n > SIDE_MAX_DEF) n = SIDE_MAX_DEF;
    return n;
  endfunction

  function automatic int vox_addr(int n, int x, int y, int z);
    return x * n * n + y * n + z;
  endfunction

  function automatic bit in_volume(int n, int x, int y, int z);
    return x < n && y < n && z < n;
  endfunction

  function automatic int corner_addr(int n, int x, int y, int z, int s, int c);
    return vox_addr(n, x - ((c & 4) != 0 ? 0 : s), y - ((c & 2) != 0 ? 0 : s),
                    z - ((c & 1) != 0 ? 0 : s));
  endfunction

  // Mask of the detail levels whose cube ends at this voxel.
  function automatic logic [7:0] cube_levels(int x, int y, int z);
    logic [7:0] mask = '0;
    int lo = loden_reg ? int'(flod_reg) : 0;
    int hi = loden_reg ? LOD_LEVELS_DEF : 1;
    int s;
    for (int lv = lo; lv < hi; lv++) begin
      s = 1 << lv;
      if (x >= s && y >= s && z >= s && (x % s) == 0 && (y % s) == 0 && (z % s) == 0)
        mask[lv] = 1'b1;
    end
    return mask;
  endfunction

  function automatic bit corners_ready(int x, int y, int z);
    int n = side_now();
    logic [7:0] mask;
    int own;
    int a;
    if (!in_volume(n, x, y, z)) return 1'b1;
    own = vox_addr(n, x, y, z);
    mask = cube_levels(x, y, z);
    for (int lv = 0; lv < 8; lv++) begin
      if (mask[lv]) begin
        for (int c = 0; c < 8; c++) begin
          a = corner_addr(n, x, y, z, 1 << lv, c);
          if (a != own && !vox_written[a]) return 1'b0;
        end
      end
    end
    return 1'b1;
  endfunction

  function automatic void predict_cells(logic [DENS_W-1:0] d, int x, int y, int z);
    int n = side_now();
    int s;
    logic [7:0] mask;
    logic [7:0] code;
    fresh_cells.delete();
    if (!in_volume(n, x, y, z)) return;
    vox_byte[vox_addr(n, x, y, z)] = d;
    vox_written[vox_addr(n, x, y, z)] = 1'b1;
    mask = cube_levels(x, y, z);
    for (int lv = 0; lv < 8; lv++) begin
      if (mask[lv]) begin
        s = 1 << lv;
        code = '0;
        for (int c = 0; c < 8; c++)
          if (vox_byte[corner_addr(n, x, y, z, s, c)] <= INSIDE_LIMIT) code[c] = 1'b1;
        if (code != CODE_ALL_OUT && code != CODE_ALL_IN)
          fresh_cells.push_back('{level: lv[LEVEL_W-1:0],
                                  cell_index: IDX_W'(vox_addr(n, x - s, y - s, z - s)),
                                  last: 1'b0});
      end
    end
    if (fresh_cells.size() != 0) fresh_cells[fresh_cells.size() - 1].last = 1'b1;
  endfunction

  function automatic int draw_wait();
    return no_idle ? 0 : $urandom_range(0, STALL_MAX);
  endfunction

  function automatic logic [DENS_W-1:0] draw_density(int p_in);
    if ($urandom_range(0, 99) < p_in) return DENS_W'($urandom_range(0, 127));
    return DENS_W'($urandom_range(128, 255));
  endfunction

  task automatic note_error(input string msg);
    err_count++;
    if (err_count <= 40) $display("%0t mismatch: %s", $time, msg);
  endtask

  // Call at a clock edge; returns at the edge where the item is taken.
  task automatic send_item(input logic [DENS_W-1:0] d, input logic [POS_W-1:0] x,
                           input logic [POS_W-1:0] y, input logic [POS_W-1:0] z,
                           input bit from_model);
    int gap = draw_wait();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_density <= d;
    in_pos_x   <= x;
    in_pos_y   <= y;
    in_pos_z   <= z;
    do @(posedge clk); while (in_stall);
    if (in_volume(side_now(), x, y, z)) item_count++;
    predict_cells(d, x, y, z);
    if (from_model) foreach (fresh_cells[i]) due_cells.push_back(fresh_cells[i]);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (due_cells.size() != 0);
  endtask

  task automatic write_reg(input cfg_reg_t sel, input logic [CFG_DATA_W-1:0] data);
    drain_results();
    repeat (IDLE_WAIT) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (sel)
      REG_SIDE:       side_reg  = data[SIDE_W-1:0];
      REG_FIRST_LOD:  flod_reg  = data[FLOD_W-1:0];
      REG_LOD_ENABLE: loden_reg = data[0];
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : result_check
    int hold;
    cell_t want;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      if (due_cells.size() == 0) begin
        note_error($sformatf("unexpected result level %0d index %0d last %0d",
                             out_level, out_cell_index, out_last));
      end else begin
        want = due_cells.pop_front();
        if (out_level !== want.level)
          note_error($sformatf("level %0d, want %0d", out_level, want.level));
        if (out_cell_index !== want.cell_index)
          note_error($sformatf("cell_index %0d, want %0d", out_cell_index, want.cell_index));
        if (out_last !== want.last)
          note_error($sformatf("last %0d, want %0d", out_last, want.last));
      end
      hold = draw_wait();
      stall_left <= hold;
      out_stall  <= (hold != 0);
    end else if (out_valid && stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= (stall_left != 1);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int n;
    int span;
    int lim;
    int drain_at;
    int p_in;
    int side_w;
    int flod;
    int x, y, z;
    int nx, ny, nz;
    int tries;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (PLAN[r]) begin
      if (PLAN[r].kind == ROW_CFG) begin
        write_reg(PLAN[r].reg_sel, PLAN[r].wdata);
      end else begin
        send_item(PLAN[r].dens, PLAN[r].px, PLAN[r].py, PLAN[r].pz, 1'b0);
        if (PLAN[r].kind == ROW_HIT)
          due_cells.push_back('{level: PLAN[r].lvl, cell_index: PLAN[r].idx, last: 1'b1});
      end
    end

    while (item_count < ITEM_TARGET) begin
      no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) != 0) side_w = $urandom_range(0, 5);
      else if ($urandom_range(0, 3) == 0) side_w = SIDE_MAX_DEF;
      else side_w = $urandom_range(6, 63);
      write_reg(REG_SIDE, CFG_DATA_W'(side_w));
      flod = $urandom_range(0, 1) ? 0 : $urandom_range(0, 7);
      write_reg(REG_FIRST_LOD, {3'($urandom_range(0, 7)), 3'(flod)});
      write_reg(REG_LOD_ENABLE, {5'($urandom_range(0, 31)), $urandom_range(0, 3) != 0});
      n = side_now();
      span = (n <= 5) ? n : $urandom_range(2, 4);
      lim = (n - 1 < span) ? n - 1 : span;
      case ($urandom_range(0, 2))
        0:       p_in = 50;
        1:       p_in = 90;
        default: p_in = 10;
      endcase
      drain_at = $urandom_range(0, span * span * span - 1);
      for (int i = 0; i < span * span * span; i++) begin
        x = i / (span * span);
        y = (i / span) % span;
        z = i % span;
        if (i == drain_at) drain_results();
        if ($urandom_range(0, 9) == 0) begin
          tries = 0;
          do begin
            nx = $urandom_range(0, lim);
            ny = $urandom_range(0, lim);
            nz = $urandom_range(0, lim);
            tries++;
          end while (!corners_ready(nx, ny, nz) && tries < 8);
          if (!corners_ready(nx, ny, nz) || $urandom_range(0, 3) == 0)
            nx = $urandom_range(n, 63);
          send_item(draw_density(p_in), POS_W'(nx), POS_W'(ny), POS_W'(nz), 1'b1);
        end
        if (corners_ready(x, y, z))
          send_item(draw_density(p_in), POS_W'(x), POS_W'(y), POS_W'(z), 1'b1);
      end
    end

    drain_results();
    repeat (IDLE_WAIT) @(posedge clk);
    if (err_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/scld_pkg.sv
sv/scld_vol.sv
sv/surface_cell_lod_detector_unit.sv
tb/tb.sv
